/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a property holds at every rising edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that a condition never shows at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/core/mht_pkg.sv */
package mht_pkg;

   localparam int KEY_W    = 64;
   localparam int HASH_W   = 64;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int LEVEL_W  = 2;
   localparam int IO_VAL_W = 32;
   localparam int CFG_W    = 4;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

   localparam logic [HASH_W-1:0] HASH_MULT = 64'hCBF29CE484222325;
   localparam logic [31:0]       HASH_LO   = HASH_MULT[31:0];
   localparam logic [31:0]       HASH_HI   = HASH_MULT[63:32];

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STS_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STS_DELETED   = 3'd4;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd5;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      logic                strobe;
      logic [STATUS_W-1:0] status;
      logic [LEVEL_W-1:0]  hit_level;
   } rsp_ctl_type;

endpackage

/* rtl/core/mht_ram.sv */
module mht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/mht_front.sv */
module mht_front
   import mht_pkg::*;
#(
   parameter int SW = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [OP_W-1:0]   in_op,
   input  logic [KEY_W-1:0]  in_key,
   input  logic [SW-1:0]     in_val,
   input  fifo_stat_type     q_stat,
   output logic              busy,
   output logic              push,
   output logic [OP_W-1:0]   out_op,
   output logic [KEY_W-1:0]  out_key,
   output logic [SW-1:0]     out_val,
   output logic [HASH_W-1:0] out_hash
);

   typedef enum logic [4:0] {
      F_IDLE = 5'b00001,
      F_MUL0 = 5'b00010,
      F_MUL1 = 5'b00100,
      F_MUL2 = 5'b01000,
      F_PUSH = 5'b10000
   } fstate_type;

   fstate_type        state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [SW-1:0]     val_ff, val_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       prod;

   assign prod = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      hash_in  = hash_ff;
      mul_a    = key_ff[31:0];
      mul_b    = HASH_LO;
      push     = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               op_in    = in_op;
               key_in   = in_key;
               val_in   = in_val;
               state_in = F_MUL0;
            end
         end
         F_MUL0: begin
            hash_in  = prod;
            state_in = F_MUL1;
         end
         F_MUL1: begin
            mul_a    = key_ff[63:32];
            hash_in  = {hash_ff[63:32] + prod[31:0], hash_ff[31:0]};
            state_in = F_MUL2;
         end
         F_MUL2: begin
            mul_b    = HASH_HI;
            hash_in  = {hash_ff[63:32] + prod[31:0], hash_ff[31:0]};
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_stat.full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      hash_ff <= hash_in;
   end

   assign busy     = (state_ff != F_IDLE);
   assign out_op   = op_ff;
   assign out_key  = key_ff;
   assign out_val  = val_ff;
   assign out_hash = hash_ff;

endmodule

/* rtl/core/mht_queue.sv */
module mht_queue
   import mht_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output fifo_stat_type    stat
);

   logic [WIDTH-1:0]   entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
      logic [Q_PTR_W-1:0] r;
      r = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

/* rtl/core/mht_back.sv */
module mht_back
   import mht_pkg::*;
#(
   parameter int LEVELS         = 4,
   parameter int MAX_FIRST_BITS = 10,
   parameter int SW             = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CFG_W-1:0]    cfg_bits,
   input  fifo_stat_type       q_stat,
   input  logic [OP_W-1:0]     q_op,
   input  logic [KEY_W-1:0]    q_key,
   input  logic [SW-1:0]       q_val,
   input  logic [HASH_W-1:0]   q_hash,
   output logic                pop,
   output logic                clearing,
   output rsp_ctl_type         rsp_ctl,
   output logic [IO_VAL_W-1:0] rsp_value
);

   localparam int DEPTH = ((1 << LEVELS) - 1) << MAX_FIRST_BITS;
   localparam int AW    = $clog2(DEPTH);
   localparam int TOP_W = MAX_FIRST_BITS + LEVELS - 1;
   localparam int SH_W  = $clog2(TOP_W + 1);
   localparam int LV_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int DW    = KEY_W + SW;

   typedef enum logic [3:0] {
      B_CLEAR = 4'b0001,
      B_IDLE  = 4'b0010,
      B_PROBE = 4'b0100,
      B_CHECK = 4'b1000
   } bstate_type;

   bstate_type          state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [SW-1:0]       val_ff, val_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [LV_W-1:0]     level_ff, level_in;
   logic [AW-1:0]       addr_ff, addr_in;
   rsp_ctl_type         rsp_ctl_ff, rsp_ctl_in;
   logic [IO_VAL_W-1:0] rsp_value_ff, rsp_value_in;

   logic [SH_W-1:0]  eff_bits, shamt;
   logic [TOP_W-1:0] idx;
   logic [AW-1:0]    lvl_mask, probe_addr;

   logic          data_we, valid_we, valid_wd;
   logic [AW-1:0] valid_waddr;
   logic [DW-1:0] data_rd;
   logic [0:0]    valid_rd;
   logic          slot_valid, slot_match, last_level;

   always_comb begin
      if (cfg_bits == '0) begin
         eff_bits = SH_W'(1);
      end else if (int'(cfg_bits) > MAX_FIRST_BITS) begin
         eff_bits = SH_W'(MAX_FIRST_BITS);
      end else begin
         eff_bits = SH_W'(cfg_bits);
      end
      shamt      = SH_W'(TOP_W) - (eff_bits + SH_W'(level_ff));
      idx        = hash_ff[HASH_W-1 -: TOP_W] >> shamt;
      lvl_mask   = (AW'(1) << level_ff) - AW'(1);
      probe_addr = (lvl_mask << MAX_FIRST_BITS) + AW'(idx);
   end

   mht_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (addr_ff),
      .wr_data ({key_ff, val_ff}),
      .rd_addr (probe_addr),
      .rd_data (data_rd)
   );

   mht_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_valid_ram (
      .clock   (clock),
      .wr_en   (valid_we),
      .wr_addr (valid_waddr),
      .wr_data (valid_wd),
      .rd_addr (probe_addr),
      .rd_data (valid_rd)
   );

   assign slot_valid = valid_rd[0];
   assign slot_match = slot_valid && (data_rd[DW-1 -: KEY_W] == key_ff);
   assign last_level = (level_ff == LV_W'(LEVELS - 1));

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      hash_in      = hash_ff;
      level_in     = level_ff;
      addr_in      = addr_ff;
      rsp_ctl_in   = rsp_ctl_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ctl_in.strobe = 1'b0;
      pop          = 1'b0;
      data_we      = 1'b0;
      valid_we     = 1'b0;
      valid_wd     = 1'b0;
      valid_waddr  = addr_ff;
      unique case (state_ff)
         B_CLEAR: begin
            valid_we    = 1'b1;
            valid_waddr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_stat.empty) begin
               pop = 1'b1;
               if (q_op == OP_INSERT || q_op == OP_LOOKUP || q_op == OP_DELETE) begin
                  op_in    = q_op;
                  key_in   = q_key;
                  val_in   = q_val;
                  hash_in  = q_hash;
                  level_in = '0;
                  state_in = B_PROBE;
               end else begin
                  rsp_ctl_in   = '{strobe: 1'b1, status: STS_NOT_FOUND, hit_level: '0};
                  rsp_value_in = '0;
               end
            end
         end
         B_PROBE: begin
            addr_in  = probe_addr;
            state_in = B_CHECK;
         end
         B_CHECK: begin
            state_in = B_IDLE;
            priority if (op_ff == OP_INSERT && !slot_valid) begin
               data_we      = 1'b1;
               valid_we     = 1'b1;
               valid_wd     = 1'b1;
               rsp_ctl_in   = '{strobe: 1'b1, status: STS_INSERTED, hit_level: 2'(level_ff)};
               rsp_value_in = IO_VAL_W'(val_ff);
            end else if (slot_match) begin
               rsp_value_in = IO_VAL_W'(data_rd[SW-1:0]);
               if (op_ff == OP_INSERT) begin
                  rsp_ctl_in = '{strobe: 1'b1, status: STS_PRESENT, hit_level: 2'(level_ff)};
               end else if (op_ff == OP_DELETE) begin
                  valid_we   = 1'b1;
                  rsp_ctl_in = '{strobe: 1'b1, status: STS_DELETED, hit_level: 2'(level_ff)};
               end else begin
                  rsp_ctl_in = '{strobe: 1'b1, status: STS_FOUND, hit_level: 2'(level_ff)};
               end
            end else if (!last_level) begin
               level_in = level_ff + LV_W'(1);
               state_in = B_PROBE;
            end else begin
               rsp_value_in = '0;
               rsp_ctl_in   = '{strobe: 1'b1,
                                status: (op_ff == OP_INSERT) ? STS_FULL : STS_NOT_FOUND,
                                hit_level: '0};
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= B_CLEAR;
         clr_addr_ff       <= '0;
         rsp_ctl_ff.strobe <= 1'b0;
      end else begin
         state_ff          <= state_in;
         clr_addr_ff       <= clr_addr_in;
         rsp_ctl_ff.strobe <= rsp_ctl_in.strobe;
      end
      rsp_ctl_ff.status    <= rsp_ctl_in.status;
      rsp_ctl_ff.hit_level <= rsp_ctl_in.hit_level;
      rsp_value_ff         <= rsp_value_in;
      op_ff                <= op_in;
      key_ff               <= key_in;
      val_ff               <= val_in;
      hash_ff              <= hash_in;
      level_ff             <= level_in;
      addr_ff              <= addr_in;
   end

   assign clearing  = (state_ff == B_CLEAR);
   assign rsp_ctl   = rsp_ctl_ff;
   assign rsp_value = rsp_value_ff;

endmodule

/* rtl/core/multilevel_hash_table_core.sv */
// Multilevel key/value table. A request is taken on a rising edge with req_start high and
// req_busy low; its single result shows on the rsp_ ports for exactly one cycle, marked by
// rsp_strobe, and the receiver cannot stall it. After reset the slot valid memory is swept
// clear, one slot a cycle, over all (2^LEVELS - 1) * 2^MAX_FIRST_BITS slots (15360 by
// default), with req_busy high throughout; csr_ already takes writes. Each request passes
// through the front end (capture, three partial products of the 64-bit hash on one 32x32
// multiplier, transfer into a two-entry queue, held while the queue is full), then through
// the back end: one read of the slot memory per level probed, with registered read data.
// The result is registered from the check of the deciding level. Front and back overlap,
// so the front end takes a new request while the back end still works on earlier ones;
// with deeper probes the queue fills and req_busy holds the next request off.
module multilevel_hash_table_core
   import mht_pkg::*;
#(
   parameter int LEVELS         = 4,
   parameter int MAX_FIRST_BITS = 10,
   parameter int VALUE_WIDTH    = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_start,
   output logic                req_busy,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [IO_VAL_W-1:0] req_value,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IO_VAL_W-1:0] rsp_result_value,
   output logic [LEVEL_W-1:0]  rsp_hit_level,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_wdata
);

   localparam int SW = (VALUE_WIDTH < IO_VAL_W) ? VALUE_WIDTH : IO_VAL_W;
   localparam int EW = OP_W + KEY_W + SW + HASH_W;

   logic [CFG_W-1:0]  cfg_ff;
   logic              front_busy, clearing, accept, push, pop;
   fifo_stat_type     q_stat;
   logic [OP_W-1:0]   f_op;
   logic [KEY_W-1:0]  f_key;
   logic [SW-1:0]     f_val;
   logic [HASH_W-1:0] f_hash;
   logic [EW-1:0]     q_data;
   rsp_ctl_type       rsp_ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         cfg_ff <= csr_wdata;
      end
   end

   assign req_busy = front_busy || clearing;
   assign accept   = req_start && !req_busy;

   mht_front #(.SW(SW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_op    (req_operation),
      .in_key   (req_key),
      .in_val   (req_value[SW-1:0]),
      .q_stat   (q_stat),
      .busy     (front_busy),
      .push     (push),
      .out_op   (f_op),
      .out_key  (f_key),
      .out_val  (f_val),
      .out_hash (f_hash)
   );

   mht_queue #(.WIDTH(EW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_op, f_key, f_val, f_hash}),
      .pop       (pop),
      .pop_data  (q_data),
      .stat      (q_stat)
   );

   mht_back #(
      .LEVELS         (LEVELS),
      .MAX_FIRST_BITS (MAX_FIRST_BITS),
      .SW             (SW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg_bits  (cfg_ff),
      .q_stat    (q_stat),
      .q_op      (q_data[EW-1 -: OP_W]),
      .q_key     (q_data[EW-OP_W-1 -: KEY_W]),
      .q_val     (q_data[HASH_W+SW-1 -: SW]),
      .q_hash    (q_data[HASH_W-1:0]),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_ctl   (rsp_ctl),
      .rsp_value (rsp_result_value)
   );

   assign rsp_strobe    = rsp_ctl.strobe;
   assign rsp_status    = rsp_ctl.status;
   assign rsp_hit_level = rsp_ctl.hit_level;

endmodule

/* rtl/core/mht_checker.sv */
`include "assert_macros.svh"

module mht_checker
   import mht_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_start,
   input logic                req_busy,
   input logic                rsp_strobe,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [IO_VAL_W-1:0] rsp_result_value,
   input logic [LEVEL_W-1:0]  rsp_hit_level
);

   `ASSERT_NEVER(a_status_range, clock, reset, rsp_strobe && (rsp_status > STS_FULL), "status code out of range")

   `ASSERT_HOLDS(a_miss_zero, clock, reset, rsp_strobe && (rsp_status == STS_NOT_FOUND || rsp_status == STS_FULL) |-> (rsp_result_value == '0) && (rsp_hit_level == '0), "miss or full result carries data")

   `ASSERT_HOLDS(a_busy_after_transfer, clock, reset, req_start && !req_busy |=> req_busy, "request taken on consecutive cycles")

   `ASSERT_HOLDS(a_busy_after_reset, clock, reset, $fell(reset) |-> req_busy && !rsp_strobe, "request path open during clearing sweep")

endmodule

bind multilevel_hash_table_core mht_checker u_checker (.*);

/* dv/tb_multilevel_hash_table_core.sv */
`timescale 1ns / 100ps
module tb_multilevel_hash_table_core;
   import mht_pkg::*;

   localparam int LEVELS         = 4;
   localparam int MAX_FIRST_BITS = 10;
   localparam int VALUE_WIDTH    = 32;
   localparam int LEVEL0_SLOTS   = 1 << MAX_FIRST_BITS;
   localparam int TOTAL_SLOTS    = LEVEL0_SLOTS * ((1 << LEVELS) - 1);
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int POOL_SIZE      = 32;
   localparam int PHASE_ITEMS    = 172;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IO_VAL_W-1:0] value;
      logic [LEVEL_W-1:0]  level;
   } table_result_type;

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_start        = 1'b0;
   logic                req_busy;
   logic [OP_W-1:0]     req_operation    = OP_LOOKUP;
   logic [KEY_W-1:0]    req_key          = '0;
   logic [IO_VAL_W-1:0] req_value        = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [IO_VAL_W-1:0] rsp_result_value;
   logic [LEVEL_W-1:0]  rsp_hit_level;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_wdata        = CFG_RESET;

   logic [CFG_W-1:0]    level0_bits      = CFG_RESET;
   logic [KEY_W-1:0]    slot_key   [TOTAL_SLOTS];
   logic [IO_VAL_W-1:0] slot_value [TOTAL_SLOTS];
   bit                  slot_used  [TOTAL_SLOTS];
   table_result_type    pending_results[$];
   table_result_type    oldest_result;
   logic [KEY_W-1:0]    key_pool [POOL_SIZE];
   logic [HASH_W-1:0]   hash_inverse;
   int                  idle_pct    = 0;
   int                  error_count = 0;
   int                  cycle_count = 0;

   multilevel_hash_table_core #(
      .LEVELS(LEVELS),
      .MAX_FIRST_BITS(MAX_FIRST_BITS),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_start(req_start),
      .req_busy(req_busy),
      .req_operation(req_operation),
      .req_key(req_key),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_result_value(rsp_result_value),
      .rsp_hit_level(rsp_hit_level),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int slot_index(input logic [KEY_W-1:0] key, input int level);
      int                unsigned bits;
      logic [HASH_W-1:0] hash;
      bits = level0_bits;
      if (bits < 1) bits = 1;
      if (bits > MAX_FIRST_BITS) bits = MAX_FIRST_BITS;
      bits = bits + level;
      hash = key * HASH_MULT;
      return LEVEL0_SLOTS * ((1 << level) - 1) + int'(hash >> (HASH_W - bits));
   endfunction

   function automatic table_result_type apply_table_op(input logic [OP_W-1:0] op,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [IO_VAL_W-1:0] value);
      table_result_type r;
      int               p;
      r.status = STS_NOT_FOUND;
      r.value  = '0;
      r.level  = '0;
      if (op == OP_INSERT) begin
         r.status = STS_FULL;
         for (int lv = 0; lv < LEVELS; lv++) begin
            p = slot_index(key, lv);
            if (!slot_used[p]) begin
               slot_used[p]  = 1'b1;
               slot_key[p]   = key;
               slot_value[p] = value;
               r.status = STS_INSERTED;
               r.value  = value;
               r.level  = LEVEL_W'(lv);
               return r;
            end
            if (slot_key[p] == key) begin
               r.status = STS_PRESENT;
               r.value  = slot_value[p];
               r.level  = LEVEL_W'(lv);
               return r;
            end
         end
         r.status = STS_FULL;
      end else if (op == OP_LOOKUP || op == OP_DELETE) begin
         for (int lv = 0; lv < LEVELS; lv++) begin
            p = slot_index(key, lv);
            if (slot_used[p] && slot_key[p] == key) begin
               if (op == OP_DELETE) begin
                  slot_used[p] = 1'b0;
                  r.status = STS_DELETED;
               end else begin
                  r.status = STS_FOUND;
               end
               r.value = slot_value[p];
               r.level = LEVEL_W'(lv);
               return r;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // key whose hash carries the given top 16 bits, so such keys collide on every level
   function automatic logic [KEY_W-1:0] key_with_prefix(input logic [15:0] prefix);
      logic [HASH_W-1:0] hash;
      hash = {prefix, 16'($urandom), $urandom};
      return hash * hash_inverse;
   endfunction

   task automatic send_table_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [IO_VAL_W-1:0] value);
      if ($urandom_range(99) < idle_pct) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_start     <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_value     <= value;
      do @(posedge clock); while (req_busy);
      pending_results.push_back(apply_table_op(op, key, value));
   endtask

   task automatic wait_until_drained();
      req_start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_level0_bits(input logic [CFG_W-1:0] bits);
      wait_until_drained();
      csr_valid <= 1'b1;
      csr_wdata <= bits;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      level0_bits  = bits;
   endtask

   task automatic test_field_extremes();
      logic [KEY_W-1:0] ones;
      ones = '1;
      idle_pct = 0;
      send_table_op(OP_INSERT, '0, '0);
      send_table_op(OP_INSERT, ones, '1);
      send_table_op(OP_INSERT, '0, 32'h5A5A_A5A5);
      send_table_op(OP_LOOKUP, ones, '0);
      send_table_op(OP_LOOKUP, random_key(), '1);
      send_table_op(OP_UNUSED, ones, '1);
      send_table_op(OP_DELETE, '0, '1);
      send_table_op(OP_DELETE, '0, '0);
      send_table_op(OP_DELETE, ones, '0);
   endtask

   task automatic test_deep_levels_and_full(ref logic [KEY_W-1:0] chain[5]);
      logic [15:0] prefix;
      prefix = 16'($urandom);
      for (int i = 0; i < 5; i++) chain[i] = key_with_prefix(prefix);
      write_level0_bits(4'd0);
      idle_pct = 34;
      for (int i = 0; i < 5; i++) send_table_op(OP_INSERT, chain[i], $urandom);
      send_table_op(OP_LOOKUP, chain[3], $urandom);
      send_table_op(OP_DELETE, chain[1], $urandom);
      send_table_op(OP_INSERT, chain[4], $urandom);
      send_table_op(OP_LOOKUP, chain[1], $urandom);
   endtask

   task automatic test_register_range(ref logic [KEY_W-1:0] chain[5]);
      write_level0_bits(4'd15);
      send_table_op(OP_LOOKUP, chain[0], $urandom);
      write_level0_bits(4'd1);
      send_table_op(OP_LOOKUP, chain[0], $urandom);
      send_table_op(OP_DELETE, chain[0], $urandom);
      send_table_op(OP_DELETE, chain[2], $urandom);
      send_table_op(OP_DELETE, chain[3], $urandom);
      send_table_op(OP_DELETE, chain[4], $urandom);
   endtask

   task automatic test_random_traffic();
      logic [CFG_W-1:0] phase_bits[8] = '{4'd1, 4'd10, 4'd0, 4'd15, 4'd2, 4'd4, 4'd7, 4'd1};
      int               phase_idle[4] = '{0, 59, 34, 0};
      int               pick;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      for (int ph = 0; ph < 8; ph++) begin
         write_level0_bits(phase_bits[ph]);
         idle_pct = phase_idle[ph % 4];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(99);
            if (pick < 40)      op = OP_INSERT;
            else if (pick < 65) op = OP_LOOKUP;
            else if (pick < 95) op = OP_DELETE;
            else                op = OP_UNUSED;
            // fresh keys only for reads, so no stale entries pile up
            if (op != OP_INSERT && $urandom_range(9) == 0) key = random_key();
            else key = key_pool[$urandom_range(POOL_SIZE - 1)];
            send_table_op(op, key, $urandom);
            if (i == PHASE_ITEMS / 2) wait_until_drained();
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d value %0h level %0d",
                   rsp_status, rsp_result_value, rsp_hit_level);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_status !== oldest_result.status) begin
               $error("status: expected %0d, got %0d", oldest_result.status, rsp_status);
               error_count++;
            end
            if (rsp_result_value !== oldest_result.value) begin
               $error("result_value: expected %0h, got %0h",
                      oldest_result.value, rsp_result_value);
               error_count++;
            end
            if (rsp_hit_level !== oldest_result.level) begin
               $error("hit_level: expected %0d, got %0d", oldest_result.level, rsp_hit_level);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0]  chain[5];
      logic [15:0]       prefixes[2];
      hash_inverse = HASH_MULT;
      repeat (6) hash_inverse = hash_inverse * (64'd2 - HASH_MULT * hash_inverse);
      prefixes[0] = 16'($urandom);
      prefixes[1] = 16'($urandom);
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = (i < POOL_SIZE / 2) ? key_with_prefix(prefixes[i % 2]) : random_key();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_deep_levels_and_full(chain);
      test_register_range(chain);
      test_random_traffic();
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("results outstanding at end: %0d", pending_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
